/* src/haversine_distance_defines.svh */
// Assertion macros used by the checker module.
`ifndef HAVERSINE_DISTANCE_DEFINES_SVH
`define HAVERSINE_DISTANCE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HVD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/hvd_pkg.sv */
package hvd_pkg;

  localparam int CORDIC_STAGES_DEF = 32;
  localparam int CW                = 36;  // CORDIC datapath, Q32 signed
  localparam int COORD_W           = 32;
  localparam int COS_W             = 32;  // cosine, Q30 signed
  localparam int DIST_W            = 32;
  localparam int RADIUS_W          = 23;
  localparam int SCALE_W           = 31;  // 200 * radius
  localparam int ISQ_STEPS         = 31;
  localparam int ISQ_IN_W          = 61;
  localparam int ISQ_ACC_W         = 62;
  localparam int COS_EXTRA_LAT     = 5;   // reduction stages plus rounding stage

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 23'd6378137;
  localparam logic [SCALE_W-1:0]  SCALE_RST  = SCALE_W'(RADIUS_RST) * SCALE_W'(200);
  localparam logic signed [CW-1:0] GAIN_Q32  = 36'sd2608131496;

  // Restoring long division, evaluated at elaboration only.
  function automatic logic [63:0] udiv_c(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctan(1/n) at 2^-60 scale from its series
  function automatic logic [63:0] atan_recip(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    p   = udiv_c(64'h1000_0000_0000_0000, n);
    sum = '0;
    for (int k = 0; k < 40; k++) begin
      if (p != '0) begin
        term = udiv_c(p, 64'(2 * k + 1));
        sum  = ((k & 1) != 0) ? sum - term : sum + term;
        p    = udiv_c(udiv_c(p, n), n);
      end
    end
    return sum;
  endfunction

  // CORDIC step angle atan(2^-i) in Q32, rounded to nearest
  function automatic logic [CW-1:0] atan_q32(input int i);
    logic [63:0] q;
    if (i == 0) begin
      q = atan_recip(64'd2) + atan_recip(64'd3);
    end else begin
      q = atan_recip(64'd1 << i);
    end
    return CW'((q + 64'h800_0000) >> 28);
  endfunction

  localparam logic [63:0]   QUARTER_Q60 = atan_recip(64'd2) + atan_recip(64'd3);
  localparam logic [CW-1:0] PI_Q32      = CW'(((QUARTER_Q60 << 2) + 64'h800_0000) >> 28);
  localparam logic [CW-1:0] TWO_PI_Q32  = PI_Q32 << 1;
  localparam logic [CW-1:0] HALF_PI_Q32 = PI_Q32 >> 1;

endpackage

/* src/hvd_cos.sv */
module hvd_cos #(
  parameter int STAGES = hvd_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [hvd_pkg::CW-1:0]    theta,
  output logic signed [hvd_pkg::COS_W-1:0] cos_q30
);
  import hvd_pkg::*;

  logic [CW-1:0] mag_r;
  logic [CW-1:0] red1_r;
  logic [CW-1:0] red2_r;
  logic [CW-1:0] ang_r;
  logic          neg_r;

  logic signed [CW-1:0] x_r [STAGES];
  logic signed [CW-1:0] y_r [STAGES-1];
  logic signed [CW-1:0] z_r [STAGES-1];
  logic                 ng_r [STAGES];

  logic signed [CW-1:0]    xr;
  logic signed [COS_W-1:0] cos_r;

  // range reduction into [0, pi/2] with a sign flag
  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= theta[CW-1] ? CW'(-theta) : CW'(theta);
      red1_r <= (mag_r >= TWO_PI_Q32) ? mag_r - TWO_PI_Q32 : mag_r;
      red2_r <= (red1_r > PI_Q32) ? TWO_PI_Q32 - red1_r : red1_r;
      if (red2_r > HALF_PI_Q32) begin
        ang_r <= PI_Q32 - red2_r;
        neg_r <= 1'b1;
      end else begin
        ang_r <= red2_r;
        neg_r <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic signed [CW-1:0] ATAN_I = atan_q32(i);
    logic signed [CW-1:0] xi;
    logic signed [CW-1:0] yi;
    logic signed [CW-1:0] zi;
    logic                 ni;
    if (i == 0) begin : g_first
      assign xi = GAIN_Q32;
      assign yi = '0;
      assign zi = signed'(ang_r);
      assign ni = neg_r;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign ni = ng_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]  <= (zi >= 0) ? xi - (yi >>> i) : xi + (yi >>> i);
        ng_r[i] <= ni;
      end
    end
    if (i < STAGES - 1) begin : g_yz
      always_ff @(posedge clk) begin
        if (en) begin
          y_r[i] <= (zi >= 0) ? yi + (xi >>> i) : yi - (xi >>> i);
          z_r[i] <= (zi >= 0) ? zi - ATAN_I : zi + ATAN_I;
        end
      end
    end
  end

  // round Q32 to Q30, then apply the quadrant sign
  assign xr = (x_r[STAGES-1] + 36'sd2) >>> 2;

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= COS_W'(ng_r[STAGES-1] ? -xr : xr);
    end
  end

  assign cos_q30 = cos_r;

endmodule

/* src/hvd_isqrt.sv */
module hvd_isqrt (
  input  logic                             clk,
  input  logic                             en,
  input  logic [hvd_pkg::ISQ_IN_W-1:0]     radicand,
  output logic [hvd_pkg::ISQ_STEPS-1:0]    root
);
  import hvd_pkg::*;

  logic [ISQ_ACC_W-1:0] rem_r [ISQ_STEPS-1];
  logic [ISQ_ACC_W-1:0] res_r [ISQ_STEPS];

  // one result bit per stage, from the top pair of radicand bits down
  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
    localparam logic [ISQ_ACC_W-1:0] BIT_K = ISQ_ACC_W'(1) << (2 * (ISQ_STEPS - 1 - k));
    logic [ISQ_ACC_W-1:0] rem_i;
    logic [ISQ_ACC_W-1:0] res_i;
    logic [ISQ_ACC_W-1:0] trial;
    if (k == 0) begin : g_first
      assign rem_i = ISQ_ACC_W'(radicand);
      assign res_i = '0;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign res_i = res_r[k-1];
    end
    assign trial = res_i + BIT_K;
    always_ff @(posedge clk) begin
      if (en) begin
        res_r[k] <= (rem_i >= trial) ? (res_i >> 1) + BIT_K : res_i >> 1;
      end
    end
    if (k < ISQ_STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= (rem_i >= trial) ? rem_i - trial : rem_i;
        end
      end
    end
  end

  assign root = res_r[ISQ_STEPS-1][ISQ_STEPS-1:0];

endmodule

/* src/haversine_distance.sv */
// Great-circle distance between two points on a sphere.
// Input channel (in_valid/in_ready): one item holds two points, latitude and
// longitude each in radians, signed Q3.29. Result channel (out_valid/
// out_ready): the distance in whole centimeters, saturating at 2^32-1.
// Configuration channel (cfg_valid/cfg_ready): writes the sphere radius in
// meters; cfg_ready is always high. Write it only while no item is in flight.
// Throughput: one item per cycle while the receiver takes results. Items
// pass through the two CORDIC pipelines (cosine and central angle) and the
// 31-step square root. Reset clears every valid bit of the pipeline and
// restores the radius to 6378137 m. When the receiver stalls, the whole
// pipeline holds; the input stage still takes an item while it is empty,
// so a bubble in that stage is not wasted. Nothing is lost or repeated
// under any stall pattern.
module haversine_distance #(
  parameter int CORDIC_STAGES = hvd_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [hvd_pkg::COORD_W-1:0]  in_first_lat,
  input  logic signed [hvd_pkg::COORD_W-1:0]  in_first_lon,
  input  logic signed [hvd_pkg::COORD_W-1:0]  in_second_lat,
  input  logic signed [hvd_pkg::COORD_W-1:0]  in_second_lon,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hvd_pkg::DIST_W-1:0]          out_distance_cm,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hvd_pkg::RADIUS_W-1:0]        cfg_sphere_radius_m
);
  import hvd_pkg::*;

  localparam int HW    = 34;  // haversine half terms and cos product, Q30
  localparam int MW    = 68;  // product before rounding
  localparam int AW    = 31;  // a in Q30, [0, 1]
  localparam int ZW    = 33;  // central angle, Q32, non-negative
  localparam int DEPTH = 1 + (CORDIC_STAGES + COS_EXTRA_LAT) + 5 + ISQ_STEPS
                         + CORDIC_STAGES + 3;

  localparam logic signed [HW-1:0] ONE_H    = 34'sd1073741824;
  localparam logic signed [63:0]   RND_C    = 64'sd536870912;
  localparam logic signed [MW-1:0] RND_M    = 68'sd536870912;
  localparam logic signed [MW-1:0] ONE_M    = 68'sd1073741824;
  localparam logic [AW-1:0]        ONE_A    = 31'd1073741824;

  // pipeline control: every stage but the input stage advances together
  logic en;
  logic vld_r [DEPTH];

  // configuration
  logic [SCALE_W-1:0] scale_r;
  logic [SCALE_W-1:0] scale_nxt;

  // input stage
  logic signed [COORD_W-1:0] lat1_r, lon1_r, lat2_r, lon2_r;
  logic signed [CW-1:0]      th_dlat, th_dlon, th_lat1, th_lat2;
  logic signed [COS_W-1:0]   cdlat, cdlon, c1, c2;

  // haversine term
  logic signed [HW-1:0] hlat_r, hlon_r, hlat2_r, hlon2_r, hlat3_r, prod_r;
  logic signed [63:0]   cc_r;
  logic signed [MW-1:0] m_r;
  logic signed [MW-1:0] asum;
  logic [AW-1:0]        a_r;
  logic [ISQ_IN_W-1:0]  va_r, vb_r;
  logic [ISQ_STEPS-1:0] s_root, t_root;

  // central angle
  logic signed [CW-1:0] vx_r [CORDIC_STAGES-1];
  logic signed [CW-1:0] vy_r [CORDIC_STAGES-1];
  logic signed [CW-1:0] vz_r [CORDIC_STAGES];
  logic [ZW-1:0]        zc_r;

  // scaling
  logic [SCALE_W+15:0]  pl_r;
  logic [SCALE_W+16:0]  ph_r;
  logic [64:0]          dsum;
  logic [DIST_W-1:0]    dist_r;

  assign en        = out_ready || !out_valid;
  assign in_ready  = en || !vld_r[0];
  assign out_valid = vld_r[DEPTH-1];
  assign cfg_ready = 1'b1;

  // 200 * R as 128R + 64R + 8R
  assign scale_nxt = (SCALE_W'(cfg_sphere_radius_m) << 7)
                   + (SCALE_W'(cfg_sphere_radius_m) << 6)
                   + (SCALE_W'(cfg_sphere_radius_m) << 3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RST;
    end else if (cfg_valid) begin
      scale_r <= scale_nxt;
    end
  end

  // valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      if (in_ready) begin
        vld_r[0] <= in_valid;
      end
      if (en) begin
        for (int k = 1; k < DEPTH; k++) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // input stage loads whenever it may take a new item
  always_ff @(posedge clk) begin
    if (in_ready) begin
      lat1_r <= in_first_lat;
      lon1_r <= in_first_lon;
      lat2_r <= in_second_lat;
      lon2_r <= in_second_lon;
    end
  end

  // widen Q29 to Q32
  assign th_dlat = (CW'(lat1_r) - CW'(lat2_r)) <<< 3;
  assign th_dlon = (CW'(lon1_r) - CW'(lon2_r)) <<< 3;
  assign th_lat1 = CW'(lat1_r) <<< 3;
  assign th_lat2 = CW'(lat2_r) <<< 3;

  hvd_cos #(.STAGES(CORDIC_STAGES)) u_cos_dlat (
    .clk(clk), .en(en), .theta(th_dlat), .cos_q30(cdlat));
  hvd_cos #(.STAGES(CORDIC_STAGES)) u_cos_dlon (
    .clk(clk), .en(en), .theta(th_dlon), .cos_q30(cdlon));
  hvd_cos #(.STAGES(CORDIC_STAGES)) u_cos_lat1 (
    .clk(clk), .en(en), .theta(th_lat1), .cos_q30(c1));
  hvd_cos #(.STAGES(CORDIC_STAGES)) u_cos_lat2 (
    .clk(clk), .en(en), .theta(th_lat2), .cos_q30(c2));

  // a = (1 - cos dlat)/2 + round(cos lat1 * cos lat2) * (1 - cos dlon)/2
  assign asum = MW'(hlat3_r) + ((m_r + RND_M) >>> 30);

  always_ff @(posedge clk) begin
    if (en) begin
      hlat_r  <= (ONE_H - HW'(cdlat)) >>> 1;
      hlon_r  <= (ONE_H - HW'(cdlon)) >>> 1;
      cc_r    <= 64'(c1) * 64'(c2);

      prod_r  <= HW'((cc_r + RND_C) >>> 30);
      hlat2_r <= hlat_r;
      hlon2_r <= hlon_r;

      m_r     <= MW'(prod_r) * MW'(hlon2_r);
      hlat3_r <= hlat2_r;

      if (asum < 0) begin
        a_r <= '0;
      end else if (asum > ONE_M) begin
        a_r <= ONE_A;
      end else begin
        a_r <= asum[AW-1:0];
      end

      va_r <= {a_r, 30'b0};
      vb_r <= {ONE_A - a_r, 30'b0};
    end
  end

  // sqrt(a) and sqrt(1 - a), both Q30
  hvd_isqrt u_sqrt_a (.clk(clk), .en(en), .radicand(va_r), .root(s_root));
  hvd_isqrt u_sqrt_b (.clk(clk), .en(en), .radicand(vb_r), .root(t_root));

  // vectoring CORDIC: atan2(sqrt(a), sqrt(1 - a)) accumulates in z
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    localparam logic signed [CW-1:0] ATAN_I = atan_q32(i);
    logic signed [CW-1:0] xi;
    logic signed [CW-1:0] yi;
    logic signed [CW-1:0] zi;
    if (i == 0) begin : g_first
      assign xi = signed'(CW'({t_root, 2'b00}));
      assign yi = signed'(CW'({s_root, 2'b00}));
      assign zi = '0;
    end else begin : g_next
      assign xi = vx_r[i-1];
      assign yi = vy_r[i-1];
      assign zi = vz_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        vz_r[i] <= (yi >= 0) ? zi + ATAN_I : zi - ATAN_I;
      end
    end
    if (i < CORDIC_STAGES - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (en) begin
          vx_r[i] <= (yi >= 0) ? xi + (yi >>> i) : xi - (yi >>> i);
          vy_r[i] <= (yi >= 0) ? yi - (xi >>> i) : yi + (xi >>> i);
        end
      end
    end
  end

  // distance = round(z * 200 * R / 2^32), split multiply over two stages
  assign dsum = 65'({ph_r, 16'b0}) + 65'(pl_r) + 65'h0_8000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      zc_r   <= (vz_r[CORDIC_STAGES-1] < 0) ? '0 : vz_r[CORDIC_STAGES-1][ZW-1:0];
      pl_r   <= (SCALE_W+16)'(zc_r[15:0]) * (SCALE_W+16)'(scale_r);
      ph_r   <= (SCALE_W+17)'(zc_r[ZW-1:16]) * (SCALE_W+17)'(scale_r);
      dist_r <= dsum[64] ? '1 : dsum[63:32];
    end
  end

  assign out_distance_cm = dist_r;

endmodule

/* src/haversine_distance_chk.sv */
`include "haversine_distance_defines.svh"

module haversine_distance_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       cfg_ready,
  input logic [hvd_pkg::DIST_W-1:0] out_distance_cm
);

  // a stalled result holds its value
  `HVD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_distance_cm), "result changed or dropped while stalled")

  // input back-pressure only comes from a stalled result
  `HVD_ASSERT_NOW(a_in_stall, !in_ready, out_valid && !out_ready, "input stalled without output stall")

  // an empty output register never blocks the input
  `HVD_ASSERT_NOW(a_in_free, !out_valid, in_ready, "input blocked while output empty")

  // configuration writes are always taken
  `HVD_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready, "configuration port not ready")

endmodule

bind haversine_distance haversine_distance_chk u_chk (.*);

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import hvd_pkg::*;

  localparam longint COORD_MAX = 64'sd1686629713;
  localparam longint ONE_Q30   = 64'sd1073741824;
  localparam longint HALF_LSB  = 64'sd536870912;   // rounding bias for Q30 products
  localparam longint K_Q32     = 64'sd2608131496;  // CORDIC gain
  localparam int     N_STAGES  = CORDIC_STAGES_DEF;
  localparam int     N_RANDOM  = 250;              // random items per setting
  localparam int     N_DRAIN   = 2 * N_STAGES + 60;

  typedef struct packed {
    logic signed [COORD_W-1:0] lat1;
    logic signed [COORD_W-1:0] lon1;
    logic signed [COORD_W-1:0] lat2;
    logic signed [COORD_W-1:0] lon2;
  } coord_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] in_first_lat = '0;
  logic signed [COORD_W-1:0] in_first_lon = '0;
  logic signed [COORD_W-1:0] in_second_lat = '0;
  logic signed [COORD_W-1:0] in_second_lon = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DIST_W-1:0] out_distance_cm;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [RADIUS_W-1:0] cfg_sphere_radius_m = '0;

  haversine_distance u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_first_lat        (in_first_lat),
    .in_first_lon        (in_first_lon),
    .in_second_lat       (in_second_lat),
    .in_second_lon       (in_second_lon),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_distance_cm     (out_distance_cm),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_sphere_radius_m (cfg_sphere_radius_m)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: the radius copy and the arctangent steps in Q32.
  longint unsigned radius_m = 64'd6378137;
  longint          atan_step[N_STAGES];
  longint unsigned pi_q32;

  coord_pair_t     pair_q[$];       // items waiting for the driver
  logic [DIST_W-1:0] dist_q[$];     // predicted distances, oldest first
  coord_pair_t     on_bus;          // item currently offered on the input
  int              mismatches = 0;
  int              send_gap = 0;
  int              recv_gap = 0;
  bit              send_idle_on = 1'b1;
  bit              recv_idle_on = 1'b1;
  bit              squeeze_req = 1'b0;
  logic            hold_recv = 1'b0;

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // arctan(1/n) at 2^-60 scale, summed from its alternating series
  function automatic longint unsigned atan_inv_q60(input longint unsigned n);
    longint unsigned p, sum, k;
    p   = (64'd1 << 60) / n;
    sum = 0;
    k   = 0;
    while (p != 0) begin
      if (k[0]) sum -= p / (2 * k + 1);
      else sum += p / (2 * k + 1);
      p = p / n / n;
      k++;
    end
    return sum;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, probe;
    res   = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v  -= res + probe;
        res = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  // Q32 angle in, Q30 cosine out; rotation-mode CORDIC after range folding
  function automatic longint cosine_q30(input longint theta);
    longint unsigned two_pi, r;
    longint x, y, z, dx, dy;
    bit flip;
    two_pi = 2 * pi_q32;
    r      = (theta < 0) ? -theta : theta;
    flip   = 1'b0;
    r      = r % two_pi;
    if (r > pi_q32) r = two_pi - r;
    if (r > (pi_q32 >> 1)) begin
      r    = pi_q32 - r;
      flip = 1'b1;
    end
    x = K_Q32;
    y = 0;
    z = longint'(r);
    for (int i = 0; i < N_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step[i];
      end else begin
        x += dx; y -= dy; z += atan_step[i];
      end
    end
    x = (x + 2) >>> 2;
    return flip ? -x : x;
  endfunction

  function automatic logic [DIST_W-1:0] great_circle_cm(input coord_pair_t p);
    longint lat1, lon1, lat2, lon2, hlat, hlon, prod, a, x, y, z, dx, dy;
    longint unsigned span_cm;
    lat1 = longint'(p.lat1) * 8;
    lon1 = longint'(p.lon1) * 8;
    lat2 = longint'(p.lat2) * 8;
    lon2 = longint'(p.lon2) * 8;
    hlat = (ONE_Q30 - cosine_q30(lat1 - lat2)) >>> 1;
    hlon = (ONE_Q30 - cosine_q30(lon1 - lon2)) >>> 1;
    prod = (cosine_q30(lat1) * cosine_q30(lat2) + HALF_LSB) >>> 30;
    a    = hlat + ((prod * hlon + HALF_LSB) >>> 30);
    if (a < 0) a = 0;
    if (a > ONE_Q30) a = ONE_Q30;
    // central angle as atan2(sqrt(a), sqrt(1-a)), vectoring mode
    y = longint'(root_floor(longint'(a) << 30)) * 4;
    x = longint'(root_floor(longint'(ONE_Q30 - a) << 30)) * 4;
    z = 0;
    for (int i = 0; i < N_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step[i];
      end else begin
        x -= dx; y += dy; z -= atan_step[i];
      end
    end
    if (z < 0) z = 0;
    span_cm = (longint'(z) * (64'd200 * radius_m) + (64'd1 << 31)) >> 32;
    if (span_cm > 64'hFFFF_FFFF) span_cm = 64'hFFFF_FFFF;
    return span_cm[DIST_W-1:0];
  endfunction

  initial begin
    longint unsigned quarter;
    quarter      = atan_inv_q60(2) + atan_inv_q60(3);
    atan_step[0] = longint'((quarter + (64'd1 << 27)) >> 28);
    for (int i = 1; i < N_STAGES; i++)
      atan_step[i] = longint'((atan_inv_q60(64'd1 << i) + (64'd1 << 27)) >> 28);
    pi_q32 = (4 * quarter + (64'd1 << 27)) >> 28;
  end

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [COORD_W-1:0] any_coord();
    return COORD_W'(longint'($urandom_range(0, 32'd3373259426)) - COORD_MAX);
  endfunction

  // Hold a coordinate inside the legal range after an offset.
  function automatic logic signed [COORD_W-1:0] near_coord(input longint base);
    longint v;
    v = base + longint'($urandom_range(0, 2000000)) - 1000000;
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < -COORD_MAX) v = -COORD_MAX;
    return COORD_W'(v);
  endfunction

  function automatic coord_pair_t random_pair();
    coord_pair_t p;
    int mode;
    mode   = $urandom_range(0, 9);
    p.lat1 = any_coord();
    p.lon1 = any_coord();
    if (mode < 6) begin
      p.lat2 = any_coord();
      p.lon2 = any_coord();
    end else if (mode < 9) begin
      // nearby points: the small-distance end of the range
      p.lat2 = near_coord(p.lat1);
      p.lon2 = near_coord(p.lon1);
    end else begin
      p.lat2 = -p.lat1;
      p.lon2 = near_coord(longint'(p.lon1) > 0 ? longint'(p.lon1) - COORD_MAX
                                               : longint'(p.lon1) + COORD_MAX);
    end
    return p;
  endfunction

  // Driver: advance to the next pending item once the current one is taken.
  always @(posedge clk) begin
    coord_pair_t nxt;
    if (rst_n) begin
      if (in_valid && in_ready) dist_q.push_back(great_circle_cm(on_bus));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pair_q.size() > 0) begin
          nxt           = pair_q.pop_front();
          on_bus        = nxt;
          in_first_lat  <= nxt.lat1;
          in_first_lon  <= nxt.lon1;
          in_second_lat <= nxt.lat2;
          in_second_lon <= nxt.lon2;
          in_valid      <= 1'b1;
          send_gap      = send_idle_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken distance with the oldest prediction.
  always @(posedge clk) begin
    logic [DIST_W-1:0] want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (dist_q.size() == 0) begin
          flag_mismatch($sformatf("distance %0d with none predicted", out_distance_cm));
        end else begin
          want = dist_q.pop_front();
          if (out_distance_cm !== want)
            flag_mismatch($sformatf("distance_cm got %0d want %0d", out_distance_cm, want));
        end
      end
      if (hold_recv) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap  = recv_idle_on ? pick_gap() : 0;
      end
    end
  end

  // Long receiver hold-off so the pipeline fills and in_ready drops.
  initial begin
    wait (squeeze_req);
    @(posedge clk);
    hold_recv <= 1'b1;
    repeat (400) @(posedge clk);
    hold_recv <= 1'b0;
  end

  // Sample the queues away from the rising edge, then return on one.
  task automatic drain();
    do @(negedge clk);
    while (pair_q.size() != 0 || in_valid || dist_q.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_radius(input logic [RADIUS_W-1:0] r);
    cfg_valid           <= 1'b1;
    cfg_sphere_radius_m <= r;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    radius_m  = r;
    cfg_valid <= 1'b0;
  endtask

  task automatic push(input longint a, input longint b, input longint c, input longint d);
    coord_pair_t p;
    p.lat1 = COORD_W'(a);
    p.lon1 = COORD_W'(b);
    p.lat2 = COORD_W'(c);
    p.lon2 = COORD_W'(d);
    pair_q.push_back(p);
  endtask

  initial begin
    logic [RADIUS_W-1:0] radii[6];
    radii = '{23'd6378137, 23'd8388607, 23'd1, 23'd0, 23'd0, 23'd6371000};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset radius first, then the extremes of every field.
    push(0, 0, 0, 0);
    push(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    push(-COORD_MAX, -COORD_MAX, -COORD_MAX, -COORD_MAX);
    push(COORD_MAX, -COORD_MAX, -COORD_MAX, COORD_MAX);   // differences near 2*pi
    push(-COORD_MAX, COORD_MAX, COORD_MAX, -COORD_MAX);
    push(0, 0, 0, COORD_MAX);                             // antipodal on the equator
    push(0, -COORD_MAX, 0, COORD_MAX);
    push(843314857, 0, -843314857, 0);                    // pole to pole
    push(843314857, 123456789, 843314857, -987654321);    // both at a pole
    push(0, 0, 1, 0);                                     // one LSB apart
    push(0, 0, 0, -1);
    push(-1, -1, 1, 1);
    push(COORD_MAX, 0, COORD_MAX - 1, 0);
    push(400000000, 1200000000, -300000000, -1500000000);
    push(32'sh55555555, 32'sh2AAAAAAA, -32'sh55555555, -32'sh2AAAAAAA);
    push(1073741824, 1073741824, -1073741824, -1073741824);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 4) radii[ph] = RADIUS_W'($urandom_range(1, 23'h7FFFFF));
      write_radius(radii[ph]);
      send_idle_on = (ph != 2);
      recv_idle_on = (ph != 2) && (ph != 5);
      if (ph == 1) begin
        // Directed again at the largest radius: the longest distances.
        push(0, 0, 0, COORD_MAX);
        push(843314857, 0, -843314857, 0);
      end
      for (int n = 0; n < N_RANDOM; n++) pair_q.push_back(random_pair());
      if (ph == 2) squeeze_req = 1'b1;
      drain();
    end

    repeat (N_DRAIN) @(posedge clk);
    if (dist_q.size() != 0) flag_mismatch("predicted distances never arrived");
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/hvd_pkg.sv
src/hvd_cos.sv
src/hvd_isqrt.sv
src/haversine_distance.sv
src/haversine_distance_chk.sv
bench/tb_top.sv
